@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the mismatch finder RTL.
// Needs signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define AFMF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AFMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/afmf_pkg.sv @@
// Shared types, register indexes and float helpers for the mismatch finder.
// No dependencies.
package afmf_pkg;

  localparam int WORD_W     = 64;
  localparam int VLD_W      = 4;
  localparam int INDEX_W    = 16;
  localparam int LANES_MAX  = 8;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ELEM_SIZE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NAN_EQUAL  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LANE_ORDER = 2'd2;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_HALF  = 2'd1,
    SZ_WORD  = 2'd2,
    SZ_DWORD = 2'd3
  } elem_size_t;

  typedef struct packed {
    elem_size_t size;
    logic       nan_equal;
    logic       lane_order;
  } cfg_t;

  function automatic logic is_nan32(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != '0);
  endfunction

  function automatic logic is_nan64(input logic [63:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] != '0);
  endfunction

endpackage

@@ hw/rtl/afmf_if.sv @@
// Valid/ready channel interfaces for the mismatch finder word and result streams.
// Depends on afmf_pkg.
interface afmf_in_if;
  import afmf_pkg::*;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  a_word;
  logic [WORD_W-1:0]  b_word;
  logic [VLD_W-1:0]   valid_elements;
  logic               last;
  modport source (output valid, a_word, b_word, valid_elements, last, input ready);
  modport sink   (input valid, a_word, b_word, valid_elements, last, output ready);
endinterface

interface afmf_out_if;
  import afmf_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] mismatch_index;
  logic               overflow;
  modport source (output valid, found, mismatch_index, overflow, input ready);
  modport sink   (input valid, found, mismatch_index, overflow, output ready);
endinterface

@@ hw/rtl/afmf_lane_cmp.sv @@
// Lane compare: per-element difference flags of two packed words, in stream order.
// Depends on afmf_pkg.
module afmf_lane_cmp (
  input  logic [afmf_pkg::WORD_W-1:0]    a_word,
  input  logic [afmf_pkg::WORD_W-1:0]    b_word,
  input  afmf_pkg::cfg_t                 cfg,
  output logic [afmf_pkg::LANES_MAX-1:0] diff
);
  import afmf_pkg::*;

  logic [7:0] d8;
  logic [3:0] d16;
  logic [1:0] d32_raw;
  logic [1:0] d32;
  logic       d64;

  // byte differences combine upward into wider lanes
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      d8[p] = a_word[8*p +: 8] != b_word[8*p +: 8];
    end
    for (int p = 0; p < 4; p++) begin
      d16[p] = d8[2*p] | d8[2*p+1];
    end
    for (int p = 0; p < 2; p++) begin
      d32_raw[p] = d16[2*p] | d16[2*p+1];
      d32[p] = d32_raw[p] &&
               !(cfg.nan_equal && is_nan32(a_word[32*p +: 32]) &&
                 is_nan32(b_word[32*p +: 32]));
    end
    d64 = (d32_raw[0] | d32_raw[1]) &&
          !(cfg.nan_equal && is_nan64(a_word) && is_nan64(b_word));
  end

  // map physical lanes to stream order; high-first order mirrors the index
  always_comb begin
    logic [2:0] kk;
    diff = '0;
    kk   = '0;
    for (int k = 0; k < LANES_MAX; k++) begin
      kk = 3'(k);
      case (cfg.size)
        SZ_BYTE: begin
          diff[k] = d8[cfg.lane_order ? ~kk : kk];
        end
        SZ_HALF: begin
          if (k < 4) diff[k] = d16[cfg.lane_order ? ~kk[1:0] : kk[1:0]];
        end
        SZ_WORD: begin
          if (k < 2) diff[k] = d32[cfg.lane_order ? ~kk[0] : kk[0]];
        end
        SZ_DWORD: begin
          if (k < 1) diff[k] = d64;
        end
        default: diff = '0;
      endcase
    end
  end

endmodule

@@ hw/rtl/array_first_mismatch_finder.sv @@
// Top level of the array first-mismatch finder: word register, compare/encode, result register.
// Depends on afmf_pkg, afmf_if, afmf_lane_cmp and assert_macros.svh.
//
//   Channel   Dir  Handshake        Carries
//   in_ch     in   valid/ready      a_word, b_word, valid_elements, last
//   out_ch    out  valid/ready      found, mismatch_index, overflow (one per last word)
//   cfg_*     in   cfg_we only      element_size_log2, nan_equal, lane_order
//
// One word per cycle sustained while no last word waits on a stalled result: a
// transfer lands in the word register, then the lane compare, priority encode and
// count update finish into the state and result registers.
// Reset is synchronous (rst_n low) and clears config, counters and valid bits.
// A stalled result only holds back a later last word; plain words keep flowing.
`include "assert_macros.svh"

module array_first_mismatch_finder #(
  parameter int MAX_ELEMENTS = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  afmf_in_if.sink                             in_ch,
  afmf_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [afmf_pkg::REG_IDX_W-1:0]      cfg_idx,
  input  logic [afmf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import afmf_pkg::*;

  // indexes must fit mismatch_index, so the usable limit tops out at 2^16
  localparam int LIMIT = (MAX_ELEMENTS > 65536) ? 65536 : MAX_ELEMENTS;
  localparam int CNT_W = $clog2(LIMIT + 1);
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);
  localparam logic [CNT_W-1:0] LANES_C = CNT_W'(LANES_MAX);

  // configuration
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{size: SZ_BYTE, nan_equal: 1'b0, lane_order: 1'b0};
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ELEM_SIZE:  cfg_r.size       <= elem_size_t'(cfg_wdata);
        REG_NAN_EQUAL:  cfg_r.nan_equal  <= cfg_wdata[0];
        REG_LANE_ORDER: cfg_r.lane_order <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // word register
  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_a_r;
  logic [WORD_W-1:0] s1_b_r;
  logic [VLD_W-1:0]  s1_vld_r;
  logic              s1_last_r;

  logic out_valid_r;
  logic out_free;
  logic s2_go;

  // a last word needs a free result slot; other words never wait
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s2_go       = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s2_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_a_r    <= in_ch.a_word;
      s1_b_r    <= in_ch.b_word;
      s1_vld_r  <= in_ch.valid_elements;
      s1_last_r <= in_ch.last;
    end
  end

  // lane compare
  logic [LANES_MAX-1:0] diff;

  afmf_lane_cmp u_lane_cmp (
    .a_word (s1_a_r),
    .b_word (s1_b_r),
    .cfg    (cfg_r),
    .diff   (diff)
  );

  // range state
  logic [CNT_W-1:0]   seen_r,    seen_nxt;
  logic               hit_r,     hit_nxt;
  logic [INDEX_W-1:0] hit_pos_r, hit_pos_nxt;
  logic               ovf_r,     ovf_nxt;

  logic [VLD_W-1:0]     lanes;
  logic [VLD_W-1:0]     vld_c;
  logic [CNT_W-1:0]     room;
  logic [VLD_W-1:0]     avail;
  logic [VLD_W-1:0]     inc;
  logic [LANES_MAX-1:0] cmp_en;
  logic [LANES_MAX-1:0] hit_vec;
  logic [2:0]           first_k;
  logic [31:0]          pos_w;

  always_comb begin
    lanes = VLD_W'(LANES_MAX) >> cfg_r.size;
    vld_c = (s1_vld_r > lanes) ? lanes : s1_vld_r;
    // elements left before the limit, capped at one word's worth
    room  = LIMIT_C - seen_r;
    avail = (room >= LANES_C) ? VLD_W'(LANES_MAX) : room[VLD_W-1:0];
    inc   = (vld_c < avail) ? vld_c : avail;

    for (int k = 0; k < LANES_MAX; k++) begin
      cmp_en[k] = (VLD_W'(k) < inc);
    end
    hit_vec = diff & cmp_en;

    // priority encode: lowest stream lane wins
    first_k = '0;
    for (int k = LANES_MAX - 1; k >= 0; k--) begin
      if (hit_vec[k]) first_k = 3'(k);
    end
    pos_w = 32'(seen_r) + 32'(first_k);

    seen_nxt    = seen_r + CNT_W'(inc);
    ovf_nxt     = ovf_r || (vld_c > avail);
    hit_nxt     = hit_r || (hit_vec != '0);
    hit_pos_nxt = hit_r ? hit_pos_r : ((hit_vec != '0) ? pos_w[INDEX_W-1:0] : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      hit_r     <= 1'b0;
      hit_pos_r <= '0;
      ovf_r     <= 1'b0;
    end else if (s2_go) begin
      if (s1_last_r) begin
        seen_r    <= '0;
        hit_r     <= 1'b0;
        hit_pos_r <= '0;
        ovf_r     <= 1'b0;
      end else begin
        seen_r    <= seen_nxt;
        hit_r     <= hit_nxt;
        hit_pos_r <= hit_pos_nxt;
        ovf_r     <= ovf_nxt;
      end
    end
  end

  // result register
  logic               out_found_r;
  logic [INDEX_W-1:0] out_idx_r;
  logic               out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s1_last_r) begin
      out_found_r <= hit_nxt;
      out_idx_r   <= hit_pos_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.mismatch_index = out_idx_r;
  assign out_ch.overflow       = out_ovf_r;

  `AFMF_ASSERT_ALWAYS(a_count_bound, seen_r <= LIMIT_C, "element count past limit")
  `AFMF_ASSERT_ALWAYS(a_hit_below_count, !hit_r || (32'(hit_pos_r) < 32'(seen_r)), "hit past count")
  `AFMF_ASSERT_NEXT(a_last_clears, s2_go && s1_last_r, (seen_r == '0) && !hit_r && !ovf_r, "range not cleared")
  `AFMF_ASSERT_NEXT(a_last_result, s2_go && s1_last_r, out_valid_r, "last word gave no result")

endmodule

@@ bench/tb_array_first_mismatch_finder.sv @@
// Self-checking bench for array_first_mismatch_finder: directed table, random ranges.
// Depends on afmf_pkg, afmf_if and the RTL top; results are checked against an in-bench predictor.
module tb_array_first_mismatch_finder;
  import afmf_pkg::*;

  localparam int MAX_ELEMS  = 65536;
  // Counting stops at the smaller of the parameter and what a 16-bit index can hold.
  localparam int COUNT_CAP  = (MAX_ELEMS > 65536) ? 65536 : MAX_ELEMS;
  localparam int LAT_PAD    = 4;       // cycles a plain word may still be in flight
  localparam int END_PAD    = 10;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 300;     // receiver hold-off during the pressure phase
  localparam int PHASES     = 10;
  localparam int PHASE_WORDS = 185;
  localparam int N_ROWS     = 21;

  typedef struct packed {
    logic        found;
    logic [15:0] idx;
    logic        ovf;
  } verdict_t;

  typedef struct packed {
    elem_size_t  sz;
    logic        nan;
    logic        ord;
    logic [63:0] a;
    logic [63:0] b;
    logic [3:0]  ve;
    logic        lst;
    logic        typed;     // use the verdict below instead of the predictor
    verdict_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  afmf_in_if  words_bus ();
  afmf_out_if verdict_bus ();

  array_first_mismatch_finder #(
    .MAX_ELEMENTS(MAX_ELEMS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (words_bus),
    .out_ch   (verdict_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the configuration and the per-range state.
  elem_size_t  cur_size;
  logic        cur_nan;
  logic        cur_order;
  logic [16:0] elems_seen;
  logic        hit;
  logic [15:0] hit_pos;
  logic        ovf;

  verdict_t verdicts_pending[$];
  int       error_count;
  int       cycle_count;

  // Typed expectation travels with the word; set by NBA alongside valid so the
  // scoreboard sees the value belonging to the transfer it is looking at.
  logic     row_typed_on;
  verdict_t row_typed;

  int src_idle_pct;
  int sink_idle_pct;
  int hold_token;
  int hold_seen;
  int hold_left;

  // Directed table. Config columns select the register setting for the row;
  // the bench drains and rewrites registers whenever they change.
  stim_row_t directed_rows [N_ROWS] = '{
    // after reset, all equal
    '{SZ_BYTE,  1'b0, 1'b0, 64'h0, 64'h0, 4'd8, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b0}},
    // top byte of the second word differs -> element 15
    '{SZ_BYTE,  1'b0, 1'b0, '1, '1, 4'd8, 1'b0, 1'b0, '0},
    '{SZ_BYTE,  1'b0, 1'b0, 64'h0, 64'hFF00_0000_0000_0000, 4'd8, 1'b1, 1'b1,
      '{1'b1, 16'd15, 1'b0}},
    // no valid lanes: nothing compared, still a result
    '{SZ_BYTE,  1'b0, 1'b0, 64'h1, 64'h2, 4'd0, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b0}},
    // valid_elements past the lane count is clipped
    '{SZ_BYTE,  1'b0, 1'b0, 64'h0, 64'hFF00_0000_0000_0000, 4'd15, 1'b1, 1'b1,
      '{1'b1, 16'd7, 1'b0}},
    // high-first order: low byte is the last lane
    '{SZ_BYTE,  1'b0, 1'b1, 64'h0, 64'h1, 4'd8, 1'b1, 1'b1, '{1'b1, 16'd7, 1'b0}},
    '{SZ_BYTE,  1'b0, 1'b1, 64'h0, 64'h8000_0000_0000_0000, 4'd3, 1'b1, 1'b1,
      '{1'b1, 16'd0, 1'b0}},
    // halfwords: differences outside the valid lanes are ignored
    '{SZ_HALF,  1'b0, 1'b0, 64'h0, 64'hFFFF_FFFF_0000_0000, 4'd2, 1'b0, 1'b0, '0},
    '{SZ_HALF,  1'b0, 1'b0, 64'h0, 64'h1, 4'd4, 1'b1, 1'b1, '{1'b1, 16'd2, 1'b0}},
    // NaN mode has no effect on halfwords
    '{SZ_HALF,  1'b1, 1'b0, 64'h7E00, 64'h7E01, 4'd4, 1'b1, 1'b1, '{1'b1, 16'd0, 1'b0}},
    // float words, NaN pairs with distinct payloads
    '{SZ_WORD,  1'b0, 1'b0, 64'h7FC0_0000_7FC0_0000, 64'h7FC0_0001_FFC0_0000, 4'd2, 1'b1,
      1'b1, '{1'b1, 16'd0, 1'b0}},
    '{SZ_WORD,  1'b1, 1'b0, 64'h7FC0_0000_7FC0_0000, 64'h7FC0_0001_FFC0_0000, 4'd2, 1'b1,
      1'b1, '{1'b0, 16'd0, 1'b0}},
    // infinity against NaN is a real difference
    '{SZ_WORD,  1'b1, 1'b0, 64'h7F80_0000, 64'h7FC0_0000, 4'd2, 1'b1, 1'b1,
      '{1'b1, 16'd0, 1'b0}},
    '{SZ_WORD,  1'b1, 1'b1, 64'h7F80_0001_0000_0000, 64'hFF80_0001_0000_0001, 4'd2, 1'b1,
      1'b1, '{1'b1, 16'd1, 1'b0}},
    // doubles
    '{SZ_DWORD, 1'b0, 1'b0, 64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0001, 4'd1, 1'b1,
      1'b1, '{1'b1, 16'd0, 1'b0}},
    '{SZ_DWORD, 1'b1, 1'b0, 64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0001, 4'd1, 1'b1,
      1'b1, '{1'b0, 16'd0, 1'b0}},
    '{SZ_DWORD, 1'b1, 1'b0, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 4'd1, 1'b1,
      1'b1, '{1'b1, 16'd0, 1'b0}},
    // first mismatch is held against a later one
    '{SZ_DWORD, 1'b0, 1'b1, '1, 64'h0, 4'd1, 1'b0, 1'b0, '0},
    '{SZ_DWORD, 1'b0, 1'b1, 64'h0, '1, 4'd1, 1'b0, 1'b0, '0},
    '{SZ_DWORD, 1'b0, 1'b1, 64'h0, 64'h0, 4'd1, 1'b1, 1'b1, '{1'b1, 16'd0, 1'b0}},
    '{SZ_BYTE,  1'b0, 1'b0, '1, 64'hFFFF_FFFF_FFFF_FFFE, 4'd8, 1'b1, 1'b1,
      '{1'b1, 16'd0, 1'b0}}
  };

  // ---------------------------------------------------------------- clock, reset
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run-length guard: a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic float_nan(input logic [63:0] v);
    if (cur_size == SZ_WORD)
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    if (cur_size == SZ_DWORD)
      return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    return 1'b0;
  endfunction

  // Folds one word into the range state; on the last word hands back the verdict
  // and clears the range.
  function automatic void advance_range(input logic [63:0] a, input logic [63:0] b,
                                        input logic [3:0] ve, input logic lst,
                                        output verdict_t v, output bit has);
    int          w;
    int          lanes;
    int          n;
    int          shift;
    logic [63:0] mask;
    logic [63:0] ea;
    logic [63:0] eb;
    bit          differ;
    w     = 8 << cur_size;
    lanes = 8 >> cur_size;
    mask  = (cur_size == SZ_DWORD) ? '1 : ((64'd1 << w) - 64'd1);
    n     = (ve > lanes) ? lanes : ve;
    for (int k = 0; k < n; k++) begin
      if (elems_seen >= COUNT_CAP) begin
        // past the cap: not compared, not counted
        ovf = 1'b1;
        continue;
      end
      shift  = cur_order ? (64 - (k + 1) * w) : (k * w);
      ea     = (a >> shift) & mask;
      eb     = (b >> shift) & mask;
      differ = (ea != eb);
      if (differ && cur_nan && cur_size >= SZ_WORD && float_nan(ea) && float_nan(eb))
        differ = 1'b0;
      if (differ && !hit) begin
        hit     = 1'b1;
        hit_pos = elems_seen[15:0];
      end
      elems_seen = elems_seen + 17'd1;
    end
    has = lst;
    v   = '{hit, hit ? hit_pos : 16'd0, ovf};
    if (lst) begin
      elems_seen = '0;
      hit        = 1'b0;
      hit_pos    = '0;
      ovf        = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- scoreboard
  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= 10)
      $display("%s", msg);
  endfunction

  always @(posedge clk) begin : scoreboard
    verdict_t v;
    verdict_t got;
    bit       has;
    if (rst_n) begin
      if (words_bus.valid && words_bus.ready) begin
        advance_range(words_bus.a_word, words_bus.b_word, words_bus.valid_elements,
                      words_bus.last, v, has);
        if (has)
          verdicts_pending.push_back(row_typed_on ? row_typed : v);
      end
      if (verdict_bus.valid && verdict_bus.ready) begin
        got = '{verdict_bus.found, verdict_bus.mismatch_index, verdict_bus.overflow};
        if (verdicts_pending.size() == 0) begin
          note_failure($sformatf("unexpected result found=%0b idx=%0d ovf=%0b",
                                 got.found, got.idx, got.ovf));
        end else begin
          v = verdicts_pending.pop_front();
          if (got !== v)
            note_failure($sformatf(
              "result mismatch: exp found=%0b idx=%0d ovf=%0b, got found=%0b idx=%0d ovf=%0b",
              v.found, v.idx, v.ovf, got.found, got.idx, got.ovf));
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // Random ready, plus a long hold-off whenever hold_token moves.
  always @(posedge clk) begin
    if (!rst_n) begin
      verdict_bus.ready <= 1'b0;
    end else begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        verdict_bus.ready <= 1'b0;
      end else begin
        verdict_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sender side
  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  // One word transfer, with random idle cycles in front of it.
  task automatic send_word(input logic [63:0] a, input logic [63:0] b, input logic [3:0] ve,
                           input logic lst, input logic typed, input verdict_t tv);
    while ($urandom_range(99) < src_idle_pct) begin
      words_bus.valid <= 1'b0;
      @(posedge clk);
    end
    words_bus.valid          <= 1'b1;
    words_bus.a_word         <= a;
    words_bus.b_word         <= b;
    words_bus.valid_elements <= ve;
    words_bus.last           <= lst;
    row_typed_on             <= typed;
    row_typed                <= tv;
    @(posedge clk);
    while (!words_bus.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every pending result has come back, then give
  // any plain word still in the word register a few cycles to retire.
  task automatic wait_quiet();
    words_bus.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Only called while idle; writes just the registers that change.
  task automatic apply_config(input elem_size_t sz, input logic nan, input logic ord);
    bit wrote;
    wrote = 1'b0;
    if (sz != cur_size) begin
      put_reg(REG_ELEM_SIZE, CFG_DATA_W'(sz));
      cur_size = sz;
      wrote    = 1'b1;
    end
    if (nan != cur_nan) begin
      put_reg(REG_NAN_EQUAL, CFG_DATA_W'(nan));
      cur_nan = nan;
      wrote   = 1'b1;
    end
    if (ord != cur_order) begin
      put_reg(REG_LANE_ORDER, CFG_DATA_W'(ord));
      cur_order = ord;
      wrote     = 1'b1;
    end
    if (wrote)
      cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] random_nan();
    logic [63:0] r;
    r = wide_random();
    if (cur_size == SZ_WORD) begin
      r[30:23] = 8'hFF;
      if (r[22:0] == 23'd0) r[0] = 1'b1;
    end else begin
      r[62:52] = 11'h7FF;
      if (r[51:0] == 52'd0) r[0] = 1'b1;
    end
    return r;
  endfunction

  // Builds a word pair lane by lane: mostly equal lanes, some NaN pairs for the
  // float sizes, and a per-lane chance of a one-bit or random difference.
  task automatic make_words(input int diff_pct, output logic [63:0] a, output logic [63:0] b);
    int          w;
    int          lanes;
    int          shift;
    int          style;
    logic [63:0] mask;
    logic [63:0] ea;
    logic [63:0] eb;
    logic [63:0] flip;
    w     = 8 << cur_size;
    lanes = 8 >> cur_size;
    mask  = (cur_size == SZ_DWORD) ? '1 : ((64'd1 << w) - 64'd1);
    a     = '0;
    b     = '0;
    for (int k = 0; k < lanes; k++) begin
      style = $urandom_range(99);
      if (style < 5)       ea = '0;
      else if (style < 10) ea = mask;
      else                 ea = wide_random() & mask;
      eb = ea;
      if (cur_size >= SZ_WORD && $urandom_range(99) < 15) begin
        ea = random_nan() & mask;
        eb = random_nan() & mask;
      end
      if ($urandom_range(99) < diff_pct) begin
        flip = $urandom_range(1) ? (64'd1 << $urandom_range(w - 1)) : wide_random();
        flip = flip & mask;
        if (flip == '0) flip = 64'd1;
        eb = ea ^ flip;
      end
      shift = cur_order ? (64 - (k + 1) * w) : (k * w);
      a = a | (ea << shift);
      b = b | (eb << shift);
    end
  endtask

  // ---------------------------------------------------------------- main flow
  initial begin
    int          len;
    int          diff_pct;
    int          sent;
    int          lanes;
    int          pick;
    bit          paused;
    elem_size_t  sz;
    logic        nan;
    logic        ord;
    logic [63:0] a;
    logic [63:0] b;
    logic [3:0]  ve;

    // Every DUT input known from time zero.
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_idx                  = '0;
    cfg_wdata                = '0;
    words_bus.valid          = 1'b0;
    words_bus.a_word         = '0;
    words_bus.b_word         = '0;
    words_bus.valid_elements = '0;
    words_bus.last           = 1'b0;
    verdict_bus.ready        = 1'b0;
    row_typed_on             = 1'b0;
    row_typed                = '0;
    cur_size                 = SZ_BYTE;
    cur_nan                  = 1'b0;
    cur_order                = 1'b0;
    elems_seen               = '0;
    hit                      = 1'b0;
    hit_pos                  = '0;
    ovf                      = 1'b0;
    error_count              = 0;
    cycle_count              = 0;
    src_idle_pct             = 33;
    sink_idle_pct            = 33;
    hold_token               = 0;
    hold_seen                = 0;
    hold_left                = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Register changes only happen with the block drained.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].sz != cur_size || directed_rows[i].nan != cur_nan ||
          directed_rows[i].ord != cur_order) begin
        wait_quiet();
        apply_config(directed_rows[i].sz, directed_rows[i].nan, directed_rows[i].ord);
      end
      send_word(directed_rows[i].a, directed_rows[i].b, directed_rows[i].ve,
                directed_rows[i].lst, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random ranges over a sweep of settings. Phase 2 runs with no idling at all,
    // phase 4 has the receiver hold off while the sender keeps pushing, and
    // phase 6 pauses the sender mid-phase until everything has drained.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      if (ph < 8) begin
        sz  = elem_size_t'(ph % 4);
        nan = 1'(ph >> 2);
        ord = 1'((ph >> 1) ^ (ph >> 2));
      end else begin
        sz  = elem_size_t'($urandom_range(3));
        nan = 1'($urandom_range(1));
        ord = 1'($urandom_range(1));
      end
      apply_config(sz, nan, ord);
      src_idle_pct  = (ph == 2 || ph == 4) ? 0 : 33;
      sink_idle_pct = (ph == 2) ? 0 : 33;
      if (ph == 4) hold_token = hold_token + 1;
      lanes  = 8 >> cur_size;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 10)      len = 1;
        else if (pick < 90) len = $urandom_range(6, 1);
        else                len = $urandom_range(30, 7);
        case ($urandom_range(3))
          0:       diff_pct = 0;
          1:       diff_pct = 2;
          2:       diff_pct = 8;
          default: diff_pct = 30;
        endcase
        for (int i = 0; i < len; i++) begin
          make_words(diff_pct, a, b);
          // occasional noise word: unrelated second operand
          if ($urandom_range(99) < 4) b = wide_random();
          pick = $urandom_range(99);
          if (pick < 80)      ve = 4'(lanes);
          else if (pick < 90) ve = 4'($urandom_range(lanes));
          else                ve = 4'($urandom_range(15));
          send_word(a, b, ve, i == len - 1, 1'b0, '0);
        end
        sent = sent + len;
        if (ph == 6 && !paused && sent >= PHASE_WORDS / 2) begin
          wait_quiet();
          paused = 1'b1;
        end
      end
    end

    wait_quiet();
    repeat (END_PAD) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ array_first_mismatch_finder.f @@
+incdir+hw/rtl
hw/rtl/afmf_pkg.sv
hw/rtl/afmf_if.sv
hw/rtl/afmf_lane_cmp.sv
hw/rtl/array_first_mismatch_finder.sv
bench/tb_array_first_mismatch_finder.sv
